// ===== sv/safc_pkg.sv =====
// Package for the SSI angle frame checker with multi-turn unwrap.
// Holds frame layout constants, status codes and the CRC-6 function.
// No dependencies.
`default_nettype none

package safc_pkg;

  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned TurnBitsDef  = 32;

  localparam int unsigned FrameW  = 24;
  localparam int unsigned AngleW  = 14;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned CrcW    = 6;
  localparam int unsigned CrcDataW = FrameW - CrcW;
  localparam int unsigned RunErrW = 8;
  localparam int unsigned OutCntW = 32;
  localparam int unsigned OutTdataW = 128;

  localparam logic [CrcW-1:0]    CrcPoly   = 6'h03;
  localparam logic [RunErrW-1:0] RunErrMax = 8'hFF;
  localparam logic signed [AngleW:0] HalfCpr = 15'sd8192;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC       = 2'd1,
    ST_FIELD     = 2'd2,
    ST_OVERSPEED = 2'd3
  } status_e;

  // x^6+x+1, init 0, MSB first
  function automatic logic [CrcW-1:0] crc6(input logic [CrcDataW-1:0] bits);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = '0;
    for (int k = CrcDataW - 1; k >= 0; k--) begin
      fb  = bits[k] ^ crc[CrcW-1];
      crc = {crc[CrcW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ssi_angle_frame_checker_unwrap.sv =====
// SSI angle frame checker: one request in, one result out per frame.
// Throughput 1 frame per cycle while m_axis_tready_i does not stall the output.
// Input register stage, then check/unwrap logic feeding the state/result registers.
// The state registers themselves are the result register and hold while stalled.
// Asynchronous active-low reset clears all state, counters and valid flags.
// Depends on safc_pkg.
`default_nettype none

module ssi_angle_frame_checker_unwrap
  import safc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef,
  parameter int unsigned TURN_BITS  = TurnBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [FrameW-1:0]    s_axis_tdata_i,  // frame[23:0]
  input  wire logic                 s_axis_tuser_i,  // mode
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // angle[13:0], turns[45:14], field_status[49:46], consecutive_errors[57:50],
  // crc_error_count[89:58], field_error_count[121:90], zero[127:122]
  output logic [OutTdataW-1:0]      m_axis_tdata_o,
  output logic [1:0]                m_axis_tuser_o,  // status
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_data_i       // invert_direction
);

  logic                  invert_q;
  logic                  in_vld_q;
  logic                  in_mode_q;
  logic [FrameW-1:0]     in_frame_q;
  logic                  out_vld_q;
  logic                  advance;

  logic [AngleW-1:0]     last_angle_q, last_angle_d;
  logic [TURN_BITS-1:0]  turns_q, turns_d;
  logic [NibbleW-1:0]    nibble_q, nibble_d;
  logic [RunErrW-1:0]    run_err_q, run_err_d;
  logic [COUNT_BITS-1:0] crc_cnt_q, crc_cnt_d;
  logic [COUNT_BITS-1:0] fld_cnt_q, fld_cnt_d;
  status_e               status_q, status_d;

  logic [AngleW-1:0]     raw_angle;
  logic [AngleW-1:0]     angle_m;
  logic [NibbleW-1:0]    mg;
  logic                  crc_ok;
  logic signed [AngleW:0] delta;
  logic [RunErrW-1:0]    run_err_inc;
  logic signed [OutCntW-1:0] turns_ext;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      invert_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_mode_q  <= s_axis_tuser_i;
      in_frame_q <= s_axis_tdata_i;
    end
  end

  // frame check
  assign raw_angle = in_frame_q[FrameW-1 -: AngleW];
  assign mg        = in_frame_q[CrcW +: NibbleW];
  assign crc_ok    = (crc6(in_frame_q[FrameW-1 -: CrcDataW]) == in_frame_q[CrcW-1:0]);
  assign angle_m   = invert_q ? (AngleW'(0) - raw_angle) : raw_angle;
  assign delta     = $signed({1'b0, angle_m}) - $signed({1'b0, last_angle_q});
  assign run_err_inc = (run_err_q == RunErrMax) ? run_err_q : run_err_q + 1'b1;

  always_comb begin
    priority if (!crc_ok) begin
      status_d = ST_CRC;
    end else if (mg[1:0] != 2'b00) begin
      status_d = ST_FIELD;
    end else if (mg[3]) begin
      status_d = ST_OVERSPEED;
    end else begin
      status_d = ST_OK;
    end
  end

  always_comb begin
    last_angle_d = last_angle_q;
    turns_d      = turns_q;
    nibble_d     = nibble_q;
    run_err_d    = run_err_q;
    crc_cnt_d    = crc_cnt_q;
    fld_cnt_d    = fld_cnt_q;
    if (in_mode_q) begin
      turns_d   = '0;
      run_err_d = '0;
      crc_cnt_d = '0;
      fld_cnt_d = '0;
      if (status_d == ST_OK || status_d == ST_OVERSPEED) begin
        last_angle_d = angle_m;
        nibble_d     = mg;
      end
    end else begin
      unique case (status_d)
        ST_CRC: begin
          crc_cnt_d = crc_cnt_q + 1'b1;
          run_err_d = run_err_inc;
        end
        ST_FIELD: begin
          nibble_d  = mg;
          fld_cnt_d = fld_cnt_q + 1'b1;
          run_err_d = run_err_inc;
        end
        default: begin
          nibble_d     = mg;
          last_angle_d = angle_m;
          run_err_d    = '0;
          if (delta > HalfCpr) begin
            turns_d = turns_q - 1'b1;
          end else if (delta < -HalfCpr) begin
            turns_d = turns_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q <= '0;
      turns_q      <= '0;
      nibble_q     <= '0;
      run_err_q    <= '0;
      crc_cnt_q    <= '0;
      fld_cnt_q    <= '0;
      status_q     <= ST_OK;
    end else if (advance) begin
      last_angle_q <= last_angle_d;
      turns_q      <= turns_d;
      nibble_q     <= nibble_d;
      run_err_q    <= run_err_d;
      crc_cnt_q    <= crc_cnt_d;
      fld_cnt_q    <= fld_cnt_d;
      status_q     <= status_d;
    end
  end

  assign turns_ext       = OutCntW'(signed'(turns_q));
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {
    6'd0,
    OutCntW'(fld_cnt_q),
    OutCntW'(crc_cnt_q),
    run_err_q,
    nibble_q,
    turns_ext,
    last_angle_q
  };

`ifndef NO_ASSERTIONS
  a_preload_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_mode_q |=> turns_q == '0 && run_err_q == '0 &&
                             crc_cnt_q == '0 && fld_cnt_q == '0)
    else $error("preload did not clear counters");

  a_good_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_mode_q && (status_d == ST_OK || status_d == ST_OVERSPEED)
    |=> run_err_q == '0)
    else $error("valid frame did not clear run errors");

  a_bad_holds_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_mode_q && (status_d == ST_CRC || status_d == ST_FIELD)
    |=> $stable(last_angle_q) && $stable(turns_q))
    else $error("angle moved on a bad frame");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(status_q))
    else $error("result changed while stalled");

  a_pending_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced item lost");
`endif

endmodule

`default_nettype wire
